@@ rtl/rhsv_pkg.sv @@
// shared types, constants and divider step for the rgb to hsv pixel unit
package rhsv_pkg;

	localparam int DIV_STEPS = 8;
	localparam int WORK_W    = 16;
	localparam int PIX_W     = 8;
	localparam int HQ_W      = 5;

	localparam logic [WORK_W-1:0] HSV_FULL       = 16'd255;
	localparam logic [WORK_W-1:0] HSV_STEP       = 16'd30;
	localparam logic [PIX_W-1:0]  HSV_GREEN_BASE = 8'd60;
	localparam logic [PIX_W-1:0]  HSV_BLUE_BASE  = 8'd120;
	localparam logic [PIX_W-1:0]  HSV_WRAP       = 8'd180;

	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sect_t;

	typedef struct packed {
		logic [WORK_W-1:0] srem;
		logic [WORK_W-1:0] sdiv;
		logic [PIX_W-1:0]  sq;
		logic [WORK_W-1:0] hrem;
		logic [WORK_W-1:0] hdiv;
		logic [PIX_W-1:0]  hq;
		logic [PIX_W-1:0]  val;
		logic              grey;
		logic              neg;
		sect_t             sect;
	} work_t;

	// one restoring step for both the saturation and the hue division
	function automatic work_t div_step(input work_t w);
		work_t r;
		logic  sbit;
		logic  hbit;
		r    = w;
		sbit = (w.srem >= w.sdiv);
		hbit = (w.hrem >= w.hdiv);
		if (sbit) begin
			r.srem = w.srem - w.sdiv;
		end
		if (hbit) begin
			r.hrem = w.hrem - w.hdiv;
		end
		r.sq   = {w.sq[PIX_W-2:0], sbit};
		r.hq   = {w.hq[PIX_W-2:0], hbit};
		r.sdiv = w.sdiv >> 1;
		r.hdiv = w.hdiv >> 1;
		return r;
	endfunction

endpackage

@@ rtl/rgb_to_hsv_pixel_unit.sv @@
// top level: rgb to hsv pixel pipeline
//
//  channel | valid     | stall     | word
//  --------+-----------+-----------+---------------------------
//  pixel   | pix_valid | pix_stall | blue_in, green_in, red_in
//  hsv     | hsv_valid | hsv_stall | hue_out, sat_out, val_out
//
// one pixel per clock unless the output stalls; one set-up stage,
// eight restoring divider stages (one quotient bit each), one output stage
// both dividers (saturation and hue) share the same stage registers
// reset clears the valid bits only
// a stalled output word freezes the whole pipeline; pix_stall follows it
module rgb_to_hsv_pixel_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pix_valid,
	output logic       pix_stall,
	input  logic [7:0] blue_in,
	input  logic [7:0] green_in,
	input  logic [7:0] red_in,
	output logic       hsv_valid,
	input  logic       hsv_stall,
	output logic [7:0] hue_out,
	output logic [7:0] sat_out,
	output logic [7:0] val_out
);

	logic            adv;
	logic            vld_s [rhsv_pkg::DIV_STEPS+1];
	rhsv_pkg::work_t wrk_s [rhsv_pkg::DIV_STEPS+1];

	assign adv       = !hsv_valid || !hsv_stall;
	assign pix_stall = !adv;

	rhsv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.pix_valid (pix_valid),
		.blue_in   (blue_in),
		.green_in  (green_in),
		.red_in    (red_in),
		.vld_s1    (vld_s[0]),
		.wrk_s1    (wrk_s[0])
	);

	for (genvar i = 0; i < rhsv_pkg::DIV_STEPS; i++) begin : g_div
		rhsv_div_stage u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.vld_in (vld_s[i]),
			.wrk_in (wrk_s[i]),
			.vld_s  (vld_s[i+1]),
			.wrk_s  (wrk_s[i+1])
		);
	end

	rhsv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.vld_in    (vld_s[rhsv_pkg::DIV_STEPS]),
		.wrk_in    (wrk_s[rhsv_pkg::DIV_STEPS]),
		.hsv_valid (hsv_valid),
		.hue_out   (hue_out),
		.sat_out   (sat_out),
		.val_out   (val_out)
	);

endmodule

@@ rtl/rhsv_front.sv @@
// first stage: max, min, sector choice and divider set-up
module rhsv_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 pix_valid,
	input  logic [7:0]           blue_in,
	input  logic [7:0]           green_in,
	input  logic [7:0]           red_in,
	output logic                 vld_s1,
	output rhsv_pkg::work_t      wrk_s1
);

	logic [7:0]      hi;
	logic [7:0]      lo;
	logic [7:0]      dif;
	logic [7:0]      mag;
	logic            neg;
	rhsv_pkg::sect_t sect;
	rhsv_pkg::work_t wrk;

	always_comb begin
		hi = red_in;
		lo = red_in;
		if (green_in > hi) hi = green_in;
		if (blue_in > hi) hi = blue_in;
		if (green_in < lo) lo = green_in;
		if (blue_in < lo) lo = blue_in;
		dif = hi - lo;

		if (hi == red_in) begin
			sect = rhsv_pkg::SECT_RED;
			neg  = (blue_in > green_in);
			mag  = neg ? (blue_in - green_in) : (green_in - blue_in);
		end else if (hi == green_in) begin
			sect = rhsv_pkg::SECT_GREEN;
			neg  = (red_in > blue_in);
			mag  = neg ? (red_in - blue_in) : (blue_in - red_in);
		end else begin
			sect = rhsv_pkg::SECT_BLUE;
			neg  = (green_in > red_in);
			mag  = neg ? (green_in - red_in) : (red_in - green_in);
		end

		wrk.srem = {8'd0, dif} * rhsv_pkg::HSV_FULL;
		wrk.sdiv = {1'b0, hi, 7'd0};
		wrk.sq   = '0;
		wrk.hrem = {8'd0, mag} * rhsv_pkg::HSV_STEP;
		wrk.hdiv = {1'b0, dif, 7'd0};
		wrk.hq   = '0;
		wrk.val  = hi;
		wrk.grey = (dif == 8'd0);
		wrk.neg  = neg;
		wrk.sect = sect;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wrk_s1 <= wrk;
		end
	end

endmodule

@@ rtl/rhsv_div_stage.sv @@
// one pipelined quotient bit for the saturation and hue dividers
module rhsv_div_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            vld_in,
	input  rhsv_pkg::work_t wrk_in,
	output logic            vld_s,
	output rhsv_pkg::work_t wrk_s
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= 1'b0;
		end else if (adv) begin
			vld_s <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wrk_s <= rhsv_pkg::div_step(wrk_in);
		end
	end

endmodule

@@ rtl/rhsv_back.sv @@
// last stage: hue from sector and quotient, output register
module rhsv_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            vld_in,
	input  rhsv_pkg::work_t wrk_in,
	output logic            hsv_valid,
	output logic [7:0]      hue_out,
	output logic [7:0]      sat_out,
	output logic [7:0]      val_out
);

	logic [rhsv_pkg::HQ_W-1:0] q;
	logic [7:0]                qx;
	logic [7:0]                hue;
	logic [7:0]                sat;

	always_comb begin
		q  = wrk_in.hq[rhsv_pkg::HQ_W-1:0];
		qx = {{(8-rhsv_pkg::HQ_W){1'b0}}, q};
		case (wrk_in.sect)
			rhsv_pkg::SECT_RED: begin
				if (wrk_in.neg && qx != 8'd0) begin
					hue = rhsv_pkg::HSV_WRAP - qx;
				end else begin
					hue = qx;
				end
			end
			rhsv_pkg::SECT_GREEN: begin
				hue = wrk_in.neg ? (rhsv_pkg::HSV_GREEN_BASE - qx)
				                 : (rhsv_pkg::HSV_GREEN_BASE + qx);
			end
			default: begin
				hue = wrk_in.neg ? (rhsv_pkg::HSV_BLUE_BASE - qx)
				                 : (rhsv_pkg::HSV_BLUE_BASE + qx);
			end
		endcase
		if (wrk_in.grey) begin
			hue = 8'd0;
		end
		sat = (wrk_in.val == 8'd0) ? 8'd0 : wrk_in.sq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsv_valid <= 1'b0;
		end else if (adv) begin
			hsv_valid <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hue_out <= hue;
			sat_out <= sat;
			val_out <= wrk_in.val;
		end
	end

endmodule

@@ rtl/rhsv_checker.sv @@
// port checker for the rgb to hsv pixel unit and its bind
module rhsv_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       pix_valid,
	input logic       pix_stall,
	input logic [7:0] blue_in,
	input logic [7:0] green_in,
	input logic [7:0] red_in,
	input logic       hsv_valid,
	input logic       hsv_stall,
	input logic [7:0] hue_out,
	input logic [7:0] sat_out,
	input logic [7:0] val_out
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && hsv_stall |=> hsv_valid && $stable(hue_out) && $stable(sat_out)
			&& $stable(val_out))
		else $error("stalled hsv word changed");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> hsv_valid && hsv_stall)
		else $error("pixel stalled without output back-pressure");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> hue_out < 8'd180)
		else $error("hue out of range");

	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && sat_out == 8'd0 |-> hue_out == 8'd0)
		else $error("grey word with non-zero hue");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && val_out == 8'd0 |-> sat_out == 8'd0)
		else $error("black word with non-zero saturation");

endmodule

bind rgb_to_hsv_pixel_unit rhsv_checker u_rhsv_checker (.*);
